### sv/ble_apf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_apf_pkg
// shared types and constants of the advertising filter with proximity trigger
// ----------------------------------------------------------------------------
package ble_apf_pkg;

  // structure type codes
  localparam logic [7:0] TYPE_FLAGS = 8'h01;
  localparam logic [7:0] TYPE_MANUF = 8'hFF;
  localparam logic [7:0] TYPE_NAME  = 8'h09;

  // structure positions within a report
  localparam logic [1:0] FIELD_FLAGS = 2'd0;
  localparam logic [1:0] FIELD_MANUF = 2'd1;
  localparam logic [1:0] FIELD_DONE  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ADV_TYPE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPANY_ID = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RSSI_THR   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_MS  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIG_COUNT = 3'd4;

  // register reset values
  localparam logic [3:0]  RST_ADV_TYPE   = 4'd3;
  localparam logic [15:0] RST_COMPANY_ID = 16'h1234;
  localparam logic [7:0]  RST_RSSI_THR   = 8'hBD;   // -67 dBm
  localparam logic [15:0] RST_WINDOW_MS  = 16'd5000;
  localparam logic [3:0]  RST_TRIG_COUNT = 4'd5;

  typedef struct packed {
    logic [3:0]         expected_adv_type;
    logic [15:0]        company_id;
    logic signed [7:0]  rssi_floor;
    logic [15:0]        window_ms;
    logic [3:0]         trigger_count;
  } cfg_t;

  // parser verdict for the word being consumed
  typedef struct packed {
    logic last;
    logic format_ok;
  } parse_status_t;

endpackage

### sv/ble_apf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_apf_parser
// length-type-data walker over the payload bytes of one report
// ----------------------------------------------------------------------------
module ble_apf_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [7:0]                 data_byte,
  input  logic                       first_byte,
  input  logic                       last_byte,
  input  logic [15:0]                company_id,
  output ble_apf_pkg::parse_status_t status
);
  import ble_apf_pkg::*;

  logic [1:0] field_index, field_index_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [1:0] byte_in_field, byte_in_field_next;  // saturates at 3
  logic       format_failed, format_failed_next;
  logic [7:0] id_low_byte, id_low_byte_next;
  logic       id_matched, id_matched_next;

  logic [1:0] fi;
  logic [7:0] left;
  logic [1:0] bif;
  logic       failed;
  logic [7:0] id_lo;
  logic       id_ok;
  logic [7:0] want;

  always_comb begin
    // start of report clears the walker
    fi     = first_byte ? 2'd0 : field_index;
    left   = first_byte ? 8'd0 : bytes_left;
    bif    = first_byte ? 2'd0 : byte_in_field;
    failed = first_byte ? 1'b0 : format_failed;
    id_lo  = first_byte ? 8'd0 : id_low_byte;
    id_ok  = first_byte ? 1'b0 : id_matched;

    unique case (fi)
      FIELD_FLAGS: want = TYPE_FLAGS;
      FIELD_MANUF: want = TYPE_MANUF;
      default:     want = TYPE_NAME;
    endcase

    if (!failed) begin
      if (left == 8'd0) begin
        // length byte
        if (data_byte == 8'd0 || fi == FIELD_DONE) begin
          failed = 1'b1;
        end else begin
          left = data_byte;
          bif  = 2'd0;
        end
      end else begin
        if (bif == 2'd0) begin
          if (data_byte != want) failed = 1'b1;
        end else if (fi == FIELD_MANUF && bif == 2'd1) begin
          id_lo = data_byte;
        end else if (fi == FIELD_MANUF && bif == 2'd2) begin
          id_ok = ({data_byte, id_lo} == company_id);
        end
        if (!failed) begin
          if (bif != 2'd3) bif = bif + 2'd1;
          left = left - 8'd1;
          if (left == 8'd0) begin
            // structure complete; manufacturer field must have carried the id
            if (fi == FIELD_MANUF && !id_ok) begin
              failed = 1'b1;
            end else begin
              fi  = fi + 2'd1;
              bif = 2'd0;
            end
          end
        end
      end
    end

    status.last      = last_byte;
    status.format_ok = !failed && fi == FIELD_DONE && left == 8'd0 && id_ok;

    // end of report clears the walker for the next one
    field_index_next   = last_byte ? 2'd0 : fi;
    bytes_left_next    = last_byte ? 8'd0 : left;
    byte_in_field_next = last_byte ? 2'd0 : bif;
    format_failed_next = last_byte ? 1'b0 : failed;
    id_low_byte_next   = last_byte ? 8'd0 : id_lo;
    id_matched_next    = last_byte ? 1'b0 : id_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index   <= 2'd0;
      bytes_left    <= 8'd0;
      byte_in_field <= 2'd0;
      format_failed <= 1'b0;
      id_matched    <= 1'b0;
    end else if (advance) begin
      field_index   <= field_index_next;
      bytes_left    <= bytes_left_next;
      byte_in_field <= byte_in_field_next;
      format_failed <= format_failed_next;
      id_matched    <= id_matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) id_low_byte <= id_low_byte_next;
  end

endmodule

### sv/ble_apf_prox.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_apf_prox
// report acceptance, proximity counter and last-match timestamp
// ----------------------------------------------------------------------------
module ble_apf_prox (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  ble_apf_pkg::parse_status_t status,
  input  logic                       scan_response,
  input  logic [3:0]                 adv_type,
  input  logic signed [7:0]          rssi,
  input  logic [31:0]                time_ms,
  input  ble_apf_pkg::cfg_t          cfg,
  output logic                       packet_matched,
  output logic [3:0]                 proximity_count,
  output logic                       trigger
);
  import ble_apf_pkg::*;

  logic [3:0]  match_count, match_count_next;
  logic [31:0] last_time;
  logic [31:0] gap;
  logic [4:0]  count_inc;
  logic        too_far;

  always_comb begin
    packet_matched = status.format_ok && !scan_response
                     && adv_type == cfg.expected_adv_type;
    gap       = time_ms - last_time;   // wraps at 32 bits
    too_far   = (gap > {16'd0, cfg.window_ms}) || (rssi < cfg.rssi_floor);
    count_inc = {1'b0, match_count} + 5'd1;
    trigger   = 1'b0;
    match_count_next = match_count;
    if (packet_matched) begin
      if (too_far) begin
        match_count_next = 4'd0;
      end else if (count_inc > {1'b0, cfg.trigger_count}) begin
        trigger          = 1'b1;
        match_count_next = 4'd0;
      end else begin
        match_count_next = count_inc[3:0];
      end
    end
    proximity_count = match_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= 4'd0;
      last_time   <= 32'd0;
    end else if (advance && status.last && packet_matched) begin
      match_count <= match_count_next;
      last_time   <= time_ms;
    end
  end

endmodule

### sv/ble_adv_filter_proximity_trigger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_filter_proximity_trigger_top
// advertising report filter with rssi/time based proximity trigger
// ----------------------------------------------------------------------------
// Payload bytes of an advertising report stream in one word per clock. Each
// word passes an input register, then the structure walker and the proximity
// logic, and the last byte of a report (tlast) loads one result word into the
// output register; all other bytes produce no output word. A word can be
// accepted on every clock while the output side keeps up; a result waiting
// in the output register stalls the stream only when the next report's last
// byte reaches the logic stage. The last byte passes the input register and
// the logic stage, and its result word is loaded into the output register
// and shown on the output only when that last byte leaves the logic stage.
// A report matches when it is not a scan response, its
// advertising type equals the configured one, and its payload is exactly
// flags, manufacturer data carrying the configured company id (little-endian)
// and a complete local name. Configuration registers may be written only when
// no report is in flight and the output register is empty.
module ble_adv_filter_proximity_trigger_top (
  input  logic                                    clk,
  input  logic                                    rst,
  // input stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [47:0]                             s_tdata,  // data_byte, rssi, time_ms
  input  logic [5:0]                              s_tuser,  // first_byte, scan_response, adv_type
  input  logic                                    s_tlast,  // last_byte
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [7:0]                              m_tdata,  // packet_matched, proximity_count,
                                                            // trigger, zero pad
  // configuration
  input  logic                                    cfg_we,
  input  logic [ble_apf_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ble_apf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ble_apf_pkg::*;

  cfg_t cfg;

  // input register
  logic              in_valid;
  logic [7:0]        in_data_byte;
  logic              in_first;
  logic              in_last;
  logic              in_scan;
  logic [3:0]        in_adv_type;
  logic signed [7:0] in_rssi;
  logic [31:0]       in_time;

  // output register
  logic              out_valid;
  logic              out_matched;
  logic [3:0]        out_count;
  logic              out_trigger;

  logic              advance;
  parse_status_t     status;
  logic              res_matched;
  logic [3:0]        res_count;
  logic              res_trigger;

  // a word leaves the input register unless it carries a result and the
  // output register is still full
  assign advance  = in_valid && (!in_last || !out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_adv_type <= RST_ADV_TYPE;
      cfg.company_id        <= RST_COMPANY_ID;
      cfg.rssi_floor        <= RST_RSSI_THR;
      cfg.window_ms         <= RST_WINDOW_MS;
      cfg.trigger_count     <= RST_TRIG_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ADV_TYPE:   cfg.expected_adv_type <= cfg_wdata[3:0];
        REG_COMPANY_ID: cfg.company_id        <= cfg_wdata;
        REG_RSSI_THR:   cfg.rssi_floor        <= cfg_wdata[7:0];
        REG_WINDOW_MS:  cfg.window_ms         <= cfg_wdata;
        REG_TRIG_COUNT: cfg.trigger_count     <= cfg_wdata[3:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data_byte <= s_tdata[7:0];
      in_rssi      <= s_tdata[15:8];
      in_time      <= s_tdata[47:16];
      in_first     <= s_tuser[0];
      in_scan      <= s_tuser[1];
      in_adv_type  <= s_tuser[5:2];
      in_last      <= s_tlast;
    end
  end

  ble_apf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .data_byte  (in_data_byte),
    .first_byte (in_first),
    .last_byte  (in_last),
    .company_id (cfg.company_id),
    .status     (status)
  );

  ble_apf_prox u_prox (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .status          (status),
    .scan_response   (in_scan),
    .adv_type        (in_adv_type),
    .rssi            (in_rssi),
    .time_ms         (in_time),
    .cfg             (cfg),
    .packet_matched  (res_matched),
    .proximity_count (res_count),
    .trigger         (res_trigger)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_matched <= res_matched;
      out_count   <= res_count;
      out_trigger <= res_trigger;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_trigger, out_count, out_matched};

  // a fired trigger always reports a cleared counter
  a_trig_clears_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_trigger |-> out_count == 4'd0)
    else $error("trigger reported with non-zero count");

  // no trigger without a matching report
  a_trig_needs_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_matched |-> !out_trigger)
    else $error("trigger on unmatched report");

  // a consumed last byte always leaves a result in the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> out_valid)
    else $error("result of a report was lost");

  // a held word in the input register is never overwritten
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_last) && $stable(in_time))
    else $error("stalled input word overwritten");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the advertising filter with proximity trigger
// ----------------------------------------------------------------------------
// Builds advertising reports from length-type-data structures, mostly well
// formed with random content and the rest broken in one chosen way or plain
// junk. A scoreboard class walks each accepted word through its own parser
// and proximity counter and queues the verdict that the last byte of a report
// must produce. Result words are checked field by field against the oldest
// queued verdict. The run passes through several register settings,
// the extremes among them, and idles both stream sides at random.
// ----------------------------------------------------------------------------
module testbench;
  import ble_apf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving
  localparam int LONG_HOLD      = 150;   // receiver hold-off to back up the stream
  localparam int PHASE_WORDS    = 170;   // input words per register setting
  localparam int PHASES         = 8;

  // verdict word, laid out as on m_tdata, members listed from the top bit down
  typedef struct packed {
    logic       trigger;
    logic [3:0] count;
    logic       matched;
  } verdict_t;

  // ways in which a generated report is spoilt
  typedef enum int {
    FLAW_NONE,
    FLAW_TRUNCATE,
    FLAW_TWO_ONLY,
    FLAW_EXTRA,
    FLAW_ZERO_LEN,
    FLAW_BAD_TYPE,
    FLAW_SHORT_MANUF,
    FLAW_BAD_ID,
    FLAW_JUNK
  } flaw_e;

  // --------------------------------------------------------------------------
  // scoreboard: parser and proximity counter, queue of verdicts due
  // --------------------------------------------------------------------------
  class proximity_scoreboard;
    cfg_t        cfg;
    logic [1:0]  field_idx;
    logic [7:0]  bytes_left;
    logic [7:0]  byte_pos;
    logic        failed;
    logic [7:0]  id_low;
    logic        id_ok;
    logic [3:0]  hit_count;
    logic [31:0] last_hit_ms;
    verdict_t    verdicts_due[$];
    int unsigned mismatches;

    function new();
      cfg.expected_adv_type = RST_ADV_TYPE;
      cfg.company_id        = RST_COMPANY_ID;
      cfg.rssi_floor        = RST_RSSI_THR;
      cfg.window_ms         = RST_WINDOW_MS;
      cfg.trigger_count     = RST_TRIG_COUNT;
      clear_parser();
      hit_count   = '0;
      last_hit_ms = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      unique case (idx)
        REG_ADV_TYPE:   cfg.expected_adv_type = val[3:0];
        REG_COMPANY_ID: cfg.company_id        = val;
        REG_RSSI_THR:   cfg.rssi_floor        = val[7:0];
        REG_WINDOW_MS:  cfg.window_ms         = val;
        REG_TRIG_COUNT: cfg.trigger_count     = val[3:0];
        default: ;
      endcase
    endfunction

    function void clear_parser();
      field_idx  = FIELD_FLAGS;
      bytes_left = '0;
      byte_pos   = '0;
      failed     = 1'b0;
      id_low     = '0;
      id_ok      = 1'b0;
    endfunction

    function void take_payload_byte(logic [7:0] b, logic first, logic last, logic scan,
                                    logic [3:0] kind, logic signed [7:0] rssi,
                                    logic [31:0] now_ms);
      logic [7:0]  want;
      logic [31:0] gap;
      logic [4:0]  next_count;
      verdict_t    v;
      if (first) clear_parser();
      want = (field_idx == FIELD_FLAGS) ? TYPE_FLAGS :
             (field_idx == FIELD_MANUF) ? TYPE_MANUF : TYPE_NAME;
      if (!failed) begin
        if (bytes_left == 0) begin
          // length byte of the next structure
          if (b == 8'd0 || field_idx == FIELD_DONE) failed = 1'b1;
          else begin
            bytes_left = b;
            byte_pos   = '0;
          end
        end else if (byte_pos == 0 && b != want) begin
          failed = 1'b1;
        end else begin
          if (field_idx == FIELD_MANUF && byte_pos == 8'd1) id_low = b;
          else if (field_idx == FIELD_MANUF && byte_pos == 8'd2)
            id_ok = ({b, id_low} == cfg.company_id);
          if (byte_pos != 8'hFF) byte_pos++;
          bytes_left--;
          if (bytes_left == 0) begin
            if (field_idx == FIELD_MANUF && !id_ok) failed = 1'b1;
            else begin
              field_idx++;
              byte_pos = '0;
            end
          end
        end
      end
      if (!last) return;

      v = '0;
      v.matched = !failed && field_idx == FIELD_DONE && bytes_left == 0 && id_ok &&
                  !scan && kind == cfg.expected_adv_type;
      if (v.matched) begin
        gap = now_ms - last_hit_ms;  // wraps at 32 bits
        if (gap > {16'd0, cfg.window_ms} || rssi < cfg.rssi_floor) begin
          hit_count = '0;
        end else begin
          next_count = {1'b0, hit_count} + 5'd1;
          if (next_count > {1'b0, cfg.trigger_count}) begin
            v.trigger  = 1'b1;
            next_count = '0;
          end
          hit_count = next_count[3:0];
        end
        last_hit_ms = now_ms;
      end
      v.count = hit_count;
      clear_parser();
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(logic [7:0] word);
      verdict_t want_v;
      verdict_t got_v;
      got_v = word[5:0];
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %h with no verdict due", word);
        return;
      end
      want_v = verdicts_due.pop_front();
      if (got_v.matched != want_v.matched || got_v.count != want_v.count ||
          got_v.trigger != want_v.trigger) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict mismatch: expected matched=%0d count=%0d trigger=%0d, %s",
                   want_v.matched, want_v.count, want_v.trigger,
                   $sformatf("got matched=%0d count=%0d trigger=%0d",
                             got_v.matched, got_v.count, got_v.trigger));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;   // data_byte, rssi, time_ms
  logic [5:0]            s_tuser;   // first_byte, scan_response, adv_type
  logic                  s_tlast;   // last_byte
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;   // packet_matched, proximity_count, trigger, zero pad
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ble_adv_filter_proximity_trigger_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  proximity_scoreboard sb;
  logic [7:0]  report_q[$];   // payload of the report being built
  logic [31:0] clock_ms;      // running millisecond clock for reports
  int unsigned words_sent;
  int unsigned quiet_cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          hold_req;

  // --------------------------------------------------------------------------
  // monitor and watchdog: everything sampled on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.take_payload_byte(s_tdata[7:0], s_tuser[0], s_tlast, s_tuser[1], s_tuser[5:2],
                             s_tdata[15:8], s_tdata[47:16]);
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: short random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        // long hold so that a second result backs up and the input stalls
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------
  // one word, offered from a falling edge until it is taken
  task automatic send_word(logic [7:0] d, logic f, logic l, logic sc, logic [3:0] k,
                           logic [7:0] r, logic [31:0] t);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {t, r, d};
    s_tuser  <= {k, sc, f};
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // report side-band only counts on the last byte, so other bytes carry noise
  task automatic send_report(bit first_flag, bit scan, logic [3:0] kind,
                             logic signed [7:0] rssi, logic [31:0] now_ms, bit closed);
    int n;
    n = report_q.size();
    for (int i = 0; i < n; i++) begin
      if (closed && i == n - 1)
        send_word(report_q[i], first_flag && i == 0, 1'b1, scan, kind, rssi, now_ms);
      else
        send_word(report_q[i], first_flag && i == 0, 1'b0, 1'($urandom), 4'($urandom),
                  8'($urandom), $urandom);
    end
  endtask

  function automatic logic [7:0] wrong_type(logic [7:0] t);
    return t ^ (8'd1 << $urandom_range(0, 7));
  endfunction

  // flags, manufacturer data, local name; then spoilt as asked
  task automatic build_report(flaw_e flaw, logic [15:0] id, int name_len);
    int flen;
    int mlen;
    int bad_at;
    int cut;
    report_q.delete();
    bad_at = $urandom_range(0, 2);
    if (flaw == FLAW_JUNK) begin
      repeat ($urandom_range(1, 20)) report_q.push_back(8'($urandom));
      return;
    end
    flen = $urandom_range(1, 3);
    report_q.push_back(8'(flen));
    report_q.push_back((flaw == FLAW_BAD_TYPE && bad_at == 0) ? wrong_type(TYPE_FLAGS)
                                                               : TYPE_FLAGS);
    repeat (flen - 1) report_q.push_back(8'($urandom));
    // manufacturer data: type, id low, id high, then payload
    mlen = (flaw == FLAW_SHORT_MANUF) ? $urandom_range(1, 2) : $urandom_range(3, 6);
    report_q.push_back(8'(mlen));
    report_q.push_back((flaw == FLAW_BAD_TYPE && bad_at == 1) ? wrong_type(TYPE_MANUF)
                                                               : TYPE_MANUF);
    if (mlen > 1) report_q.push_back(id[7:0]);
    if (mlen > 2) report_q.push_back(id[15:8]);
    if (mlen > 3) repeat (mlen - 3) report_q.push_back(8'($urandom));
    if (flaw != FLAW_TWO_ONLY) begin
      report_q.push_back(8'(name_len));
      report_q.push_back((flaw == FLAW_BAD_TYPE && bad_at == 2) ? wrong_type(TYPE_NAME)
                                                                 : TYPE_NAME);
      repeat (name_len - 1) report_q.push_back(8'($urandom));
    end
    if (flaw == FLAW_EXTRA) begin
      flen = $urandom_range(1, 4);
      report_q.push_back(8'(flen));
      repeat (flen) report_q.push_back(8'($urandom));
    end
    if (flaw == FLAW_ZERO_LEN) begin
      if (bad_at == 0) report_q.push_front(8'd0);
      else if (bad_at == 1) report_q.insert(flen + 1, 8'd0);
      else report_q.push_back(8'd0);
    end
    if (flaw == FLAW_TRUNCATE) begin
      cut = $urandom_range(1, report_q.size() - 1);
      repeat (cut) void'(report_q.pop_back());
    end
  endtask

  // steady phases keep the count climbing so that large trigger counts fire
  task automatic send_random_report(bit steady);
    flaw_e             flaw;
    logic [15:0]       id;
    int                name_len;
    int                win;
    int                thr;
    logic signed [7:0] rssi_v;
    logic [3:0]        kind;
    bit                scan;
    bit                first_flag;
    if ($urandom_range(0, 99) < (steady ? 95 : 70)) flaw = FLAW_NONE;
    else flaw = flaw_e'($urandom_range(1, int'(FLAW_JUNK)));
    id = sb.cfg.company_id;
    if (flaw == FLAW_BAD_ID) id = id ^ (16'd1 << $urandom_range(0, 15));
    name_len = ($urandom_range(0, 99) == 0) ? 255 : $urandom_range(1, 8);
    build_report(flaw, id, name_len);

    win = sb.cfg.window_ms;
    if ($urandom_range(0, 99) < (steady ? 1 : 4)) clock_ms = $urandom;
    else if (!steady && $urandom_range(0, 19) == 0) clock_ms += $urandom_range(win + 1, 2 * win + 1);
    else clock_ms += $urandom_range(0, steady ? win / 4 : win);
    thr = $signed(sb.cfg.rssi_floor);
    if ($urandom_range(0, 99) < (steady ? 99 : 85))
      rssi_v = 8'($urandom_range(thr + 128, 255) - 128);
    else
      rssi_v = 8'($urandom);
    kind       = ($urandom_range(0, 9) != 0) ? sb.cfg.expected_adv_type : 4'($urandom);
    scan       = ($urandom_range(0, 19) == 0);
    first_flag = ($urandom_range(0, 9) != 0);

    // now and then a report is abandoned and the next one restarts the parser
    if (!steady && $urandom_range(0, 29) == 0) begin
      send_report(1'b1, scan, kind, rssi_v, clock_ms, 1'b0);
      build_report(flaw, id, name_len);
      first_flag = 1'b1;
    end
    send_report(first_flag, scan, kind, rssi_v, clock_ms, 1'b1);
  endtask

  // stop the stream and let every result and the pipeline drain
  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_one(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_setting(cfg_t s);
    write_one(REG_ADV_TYPE,   {12'd0, s.expected_adv_type});
    write_one(REG_COMPANY_ID, s.company_id);
    write_one(REG_RSSI_THR,   {8'd0, s.rssi_floor});
    write_one(REG_WINDOW_MS,  s.window_ms);
    write_one(REG_TRIG_COUNT, {12'd0, s.trigger_count});
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t setting[PHASES];
    sb = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    s_tlast      = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    words_sent   = 0;
    quiet_cycles = 0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_req     = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed reports under the reset settings
    build_report(FLAW_NONE, 16'h1234, 3);
    send_report(1'b1, 1'b0, 4'd3, -50, 32'd100, 1'b1);        // first hit, count 1
    report_q.delete();
    report_q.push_back(8'd0);
    send_report(1'b1, 1'b0, 4'd3, -128, 32'd110, 1'b1);       // single zero length byte
    build_report(FLAW_BAD_TYPE, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd120, 1'b1);
    build_report(FLAW_SHORT_MANUF, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd130, 1'b1);
    build_report(FLAW_EXTRA, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd140, 1'b1);
    build_report(FLAW_TRUNCATE, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd150, 1'b1);
    build_report(FLAW_TWO_ONLY, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd160, 1'b1);
    build_report(FLAW_BAD_ID, 16'h1235, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd170, 1'b1);
    // report cut off without its last byte, next one restarts with first_byte
    build_report(FLAW_NONE, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd180, 1'b0);
    build_report(FLAW_NONE, 16'h1234, 2);
    send_report(1'b1, 1'b0, 4'd3, 127, 32'd200, 1'b1);       // count 2
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b0, 1'b0, 4'd3, 127, 32'd300, 1'b1);       // no first_byte, count 3
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b1, 4'd3, 127, 32'd310, 1'b1);       // scan response
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b0, 4'd4, 127, 32'd320, 1'b1);       // wrong advertising type
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b0, 4'd3, -68, 32'd400, 1'b1);       // just below threshold
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b0, 4'd3, -67, 32'd500, 1'b1);       // at threshold
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b0, 4'd3, 0, 32'hFFFF_FF00, 1'b1);   // huge gap
    build_report(FLAW_NONE, 16'h1234, 1);
    send_report(1'b1, 1'b0, 4'd3, 0, 32'h0000_0010, 1'b1);   // gap across the wrap
    build_report(FLAW_NONE, 16'h1234, 255);
    send_report(1'b1, 1'b0, 4'd3, 5, 32'h0000_0020, 1'b1);   // longest local name
    for (int i = 0; i < 5; i++) begin
      build_report(FLAW_NONE, 16'h1234, 1);
      send_report(1'b1, 1'b0, 4'd3, 10, 32'h0000_0030 + i, 1'b1);  // runs into the trigger
    end

    // register settings per phase: reset values, both extremes, a steady setting, then random
    setting[0] = sb.cfg;
    setting[1] = '{expected_adv_type: 4'd0, company_id: 16'h0000, rssi_floor: -128,
                   window_ms: 16'd0, trigger_count: 4'd0};
    setting[2] = '{expected_adv_type: 4'd15, company_id: 16'hFFFF, rssi_floor: 127,
                   window_ms: 16'hFFFF, trigger_count: 4'd15};
    setting[3] = '{expected_adv_type: 4'd15, company_id: 16'hA55A, rssi_floor: -90,
                   window_ms: 16'hFFFF, trigger_count: 4'd15};
    for (int p = 4; p < PHASES; p++) begin
      setting[p].expected_adv_type = 4'($urandom);
      setting[p].company_id        = 16'($urandom);
      setting[p].rssi_floor        = 8'($urandom_range(0, 255));
      setting[p].window_ms         = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                                 : 16'($urandom_range(0, 2000));
      setting[p].trigger_count     = 4'($urandom);
    end
    clock_ms = $urandom;

    for (int p = 0; p < PHASES; p++) begin
      int unsigned budget;
      if (p > 0) begin
        settle_idle();
        apply_setting(setting[p]);
      end
      if (p == 0) hold_req = 1'b1;
      if (p == PHASES - 1) begin
        // closing stretch runs at full rate on both sides
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      budget = words_sent + PHASE_WORDS;
      while (words_sent < budget) send_random_report(p == 3);
    end

    settle_idle();
    repeat (10) @(negedge clk);
    if (sb.mismatches == 0 && sb.verdicts_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
